// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the clock and reset controller RTL.
// Simulation builds get concurrent assertions; SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CRR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define CRR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");
`else
`define CRR_ASSERT(lbl, clk, rst, prop)
`define CRR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/crr_pkg.sv -----
// Constants and the reset value table of the clock and reset controller register file.
// Used by the interfaces and the top level; depends on nothing.
`default_nettype none
package crr_pkg;
   localparam int unsigned WORD_ADDR_WIDTH = 8;
   localparam int unsigned RATE_WIDTH      = 40;
   localparam int unsigned REF_WIDTH       = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   localparam logic [WORD_ADDR_WIDTH-1:0] W_RPLL_CTRL  = 8'h0C;
   localparam logic [WORD_ADDR_WIDTH-1:0] W_RPLL_FRAC  = 8'h0E;
   localparam logic [WORD_ADDR_WIDTH-1:0] W_LSBUS_CTRL = 8'h2B;
   localparam logic [WORD_ADDR_WIDTH-1:0] W_RESET_CTRL = 8'h86;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PS_REF    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VIDEO_REF = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALT_REF   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AUX_REF   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GT_REF    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IOPLL     = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DPLL      = 3'd6;

   localparam logic [2:0] REF_SEL_GT    = 3'd7;
   localparam logic [2:0] REF_SEL_AUX   = 3'd6;
   localparam logic [2:0] REF_SEL_ALT   = 3'd5;
   localparam logic [2:0] REF_SEL_VIDEO = 3'd4;

   localparam logic [2:0] SRC_RPLL  = 3'd0;
   localparam logic [2:0] SRC_IOPLL = 3'd2;
   localparam logic [2:0] SRC_DPLL  = 3'd3;

   localparam logic [31:0] PS_REF_RESET = 32'd33330261;
   localparam logic [31:0] RESET_REQ_MASK = 32'h0000_0010;

   function automatic logic [31:0] reset_word(input logic [WORD_ADDR_WIDTH-1:0] idx);
      logic [31:0] val;
      case (idx)
         8'h08, 8'h0C: val = 32'h00012C09;
         8'h10: val = 32'h0000001B;
         8'h11, 8'h12: val = 32'h00000400;
         8'h13, 8'h18, 8'h19, 8'h2D, 8'h30, 8'h31, 8'h32, 8'h33: val = 32'h00052000;
         8'h14, 8'h15, 8'h16, 8'h17: val = 32'h00002500;
         8'h1A: val = 32'h01000800;
         8'h1B, 8'h1C: val = 32'h01000F00;
         8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h2B, 8'h42: val = 32'h01001800;
         8'h24: val = 32'h03000600;
         8'h27, 8'h29: val = 32'h00001500;
         8'h28: val = 32'h01001500;
         8'h2A, 8'h48, 8'h49: val = 32'h01000500;
         8'h2C: val = 32'h01002000;
         8'h2E: val = 32'h00002000;
         8'h34, 8'h36, 8'h38, 8'h3A, 8'h86, 8'h88: val = 32'h00000001;
         8'h40: val = 32'h00051000;
         8'h4A: val = 32'h00001800;
         8'h51: val = 32'h0000FFFF;
         8'h8C: val = 32'h0000000F;
         8'h8E: val = 32'h0017FFFF;
         8'h8F: val = 32'h00188FDF;
         8'h90: val = 32'h00000033;
         8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hA0: val = 32'h000003FF;
         default: val = 32'h0;
      endcase
      return val;
   endfunction
endpackage
`default_nettype wire

// ----- rtl/crr_if.sv -----
// Handshake channels of the clock and reset controller: request, response, CSR write.
// Rate and CSR index widths come from crr_pkg.
`default_nettype none
interface crr_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [9:0]  byte_addr;
   logic [31:0] write_data;
   modport source(output valid, op, byte_addr, write_data, input ready);
   modport sink(input valid, op, byte_addr, write_data, output ready);
endinterface

interface crr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [31:0]                      read_data;
   logic [crr_pkg::RATE_WIDTH-1:0]   rpll_rate;
   logic [crr_pkg::RATE_WIDTH-1:0]   lsbus_rate;
   logic                             reset_request;
   logic                             source_error;
   modport source(output valid, read_data, rpll_rate, lsbus_rate, reset_request,
                  source_error, input ready);
   modport sink(input valid, read_data, rpll_rate, lsbus_rate, reset_request,
                source_error, output ready);
endinterface

interface crr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [crr_pkg::CSR_INDEX_WIDTH-1:0] reg_index;
   logic [crr_pkg::RATE_WIDTH-1:0]      reg_data;
   modport source(output valid, reg_index, reg_data, input ready);
   modport sink(input valid, reg_index, reg_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/clock_reset_ctrl_regs_top.sv -----
// Top level of the clock and reset controller register file with derived rates.
// Depends on crr_pkg, the channels in crr_if.sv and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// One request transaction reads or writes one 32-bit word and returns one response
// transaction with the word and the RPLL and low-speed bus rates. The register file
// sits in a single-port synchronous RAM with a valid bit per word, so it is usable right
// after reset with its documented values. Every transaction makes four RAM reads (the
// word, the RPLL control, the RPLL fraction and the low-speed bus control word), two
// registered multiplies and a sum; the bit-serial 40-bit divider follows only when the
// bus clock is enabled with a nonzero divisor and a valid source. Requests are
// taken one at a time; the next one is accepted while the last response still waits.
// CSR writes are accepted every cycle and must only be issued while the block is idle.
module clock_reset_ctrl_regs_top #(
   parameter int unsigned REG_WORDS = 256
) (
   input  wire logic clock,
   input  wire logic reset,
   crr_req_if.sink   req_bus,
   crr_rsp_if.source rsp_bus,
   crr_csr_if.sink   csr_bus
);
   localparam int unsigned AW        = crr_pkg::WORD_ADDR_WIDTH;
   localparam int unsigned MEM_DEPTH = (REG_WORDS < (1 << AW)) ? REG_WORDS : (1 << AW);
   localparam int unsigned RW        = crr_pkg::RATE_WIDTH;
   localparam int unsigned DIV_STEPS = RW;
   localparam int unsigned CW        = $clog2(DIV_STEPS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_IDX, S_CTRL, S_FRAC, S_LS, S_MUL, S_FMUL, S_SUM, S_DIV, S_DONE
   } state_type;

   state_type state_ff;

   logic [31:0] mem [MEM_DEPTH];
   logic        vld_ff [MEM_DEPTH];
   logic [31:0] rd_q_ff;
   logic        rd_vld_ff;
   logic [AW-1:0] rd_addr_ff;
   logic [AW-1:0] rd_addr_in;
   logic [31:0] rd_word;

   logic [31:0] ps_ref_ff, video_ref_ff, alt_ref_ff, aux_ref_ff, gt_ref_ff;
   logic [RW-1:0] iopll_ff, dpll_ff;

   logic          op_ff;
   logic [AW-1:0] idx_ff;
   logic [31:0]   wdata_ff;
   logic          in_range_ff;
   logic [31:0]   ctrl_ff, frac_ff, ls_ff;
   logic [31:0]   ref_ff;
   logic [38:0]   prod_ff;
   logic [54:0]   fprod_ff;
   logic [RW-1:0] rpll_ff;
   logic [RW-1:0] quot_ff;
   logic [5:0]    rem_ff;
   logic [5:0]    div_ff;
   logic [CW-1:0] cnt_ff;
   logic          err_ff;
   logic [31:0]   read_data_ff;
   logic          rst_req_ff;

   logic          rsp_valid_ff;
   logic [31:0]   rsp_read_data_ff;
   logic [RW-1:0] rsp_rpll_ff, rsp_lsbus_ff;
   logic          rsp_rst_req_ff, rsp_err_ff;

   logic [AW-1:0] req_idx;
   logic          req_in_range;
   logic          req_fire;
   logic          mem_we;
   logic [31:0]   ref_in;
   logic [RW-1:0] rpll_in;
   logic [RW-1:0] sum_full;
   logic [RW-1:0] src_in;
   logic          err_in;
   logic [6:0]    shifted;
   logic          fits;
   logic          rsp_free;

   assign req_idx      = req_bus.byte_addr[9:2];
   assign req_in_range = 32'(req_idx) < REG_WORDS;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire     = req_bus.valid && req_bus.ready;
   assign mem_we       = req_fire && req_bus.op && req_in_range;
   assign csr_bus.ready = 1'b1;
   assign rsp_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rd_word      = rd_vld_ff ? rd_q_ff : crr_pkg::reset_word(rd_addr_ff);

   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr_in = req_in_range ? req_idx : '0;
         S_IDX:   rd_addr_in = crr_pkg::W_RPLL_CTRL;
         S_CTRL:  rd_addr_in = crr_pkg::W_RPLL_FRAC;
         default: rd_addr_in = crr_pkg::W_LSBUS_CTRL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_idx] <= req_bus.write_data;
      end
      rd_q_ff    <= mem[rd_addr_in];
      rd_addr_ff <= rd_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEM_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[req_idx] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ref_ff    <= crr_pkg::PS_REF_RESET;
         video_ref_ff <= '0;
         alt_ref_ff   <= '0;
         aux_ref_ff   <= '0;
         gt_ref_ff    <= '0;
         iopll_ff     <= '0;
         dpll_ff      <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            crr_pkg::CSR_PS_REF:    ps_ref_ff    <= csr_bus.reg_data[31:0];
            crr_pkg::CSR_VIDEO_REF: video_ref_ff <= csr_bus.reg_data[31:0];
            crr_pkg::CSR_ALT_REF:   alt_ref_ff   <= csr_bus.reg_data[31:0];
            crr_pkg::CSR_AUX_REF:   aux_ref_ff   <= csr_bus.reg_data[31:0];
            crr_pkg::CSR_GT_REF:    gt_ref_ff    <= csr_bus.reg_data[31:0];
            crr_pkg::CSR_IOPLL:     iopll_ff     <= csr_bus.reg_data;
            crr_pkg::CSR_DPLL:      dpll_ff      <= csr_bus.reg_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ctrl_ff[26:24])
         crr_pkg::REF_SEL_GT:    ref_in = gt_ref_ff;
         crr_pkg::REF_SEL_AUX:   ref_in = aux_ref_ff;
         crr_pkg::REF_SEL_ALT:   ref_in = alt_ref_ff;
         crr_pkg::REF_SEL_VIDEO: ref_in = video_ref_ff;
         default:                ref_in = ps_ref_ff;
      endcase
   end

   always_comb begin
      sum_full = {1'b0, prod_ff} + (frac_ff[31] ? {1'b0, fprod_ff[54:16]} : '0);
      if (ctrl_ff[3]) begin
         rpll_in = RW'(ref_ff);
      end else if (ctrl_ff[0]) begin
         rpll_in = '0;
      end else if (ctrl_ff[16]) begin
         rpll_in = sum_full >> 1;
      end else begin
         rpll_in = sum_full;
      end
   end

   always_comb begin
      err_in = 1'b0;
      case (ls_ff[2:0])
         crr_pkg::SRC_RPLL:  src_in = rpll_in;
         crr_pkg::SRC_IOPLL: src_in = iopll_ff;
         crr_pkg::SRC_DPLL:  src_in = dpll_ff;
         default: begin
            src_in = '0;
            err_in = 1'b1;
         end
      endcase
   end

   assign shifted = {rem_ff, quot_ff[RW-1]};
   assign fits    = shifted >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff       <= req_bus.op;
                  idx_ff      <= req_idx;
                  wdata_ff    <= req_bus.write_data;
                  in_range_ff <= req_in_range;
                  state_ff    <= S_IDX;
               end
            end
            S_IDX: begin
               if (!in_range_ff) begin
                  read_data_ff <= '0;
               end else if (op_ff) begin
                  read_data_ff <= wdata_ff;
               end else begin
                  read_data_ff <= rd_word;
               end
               rst_req_ff <= op_ff && (idx_ff == crr_pkg::W_RESET_CTRL) &&
                             ((wdata_ff & crr_pkg::RESET_REQ_MASK) != '0);
               state_ff <= S_CTRL;
            end
            S_CTRL: begin
               ctrl_ff  <= rd_word;
               state_ff <= S_FRAC;
            end
            S_FRAC: begin
               frac_ff  <= rd_word;
               state_ff <= S_LS;
            end
            S_LS: begin
               ls_ff    <= rd_word;
               ref_ff   <= ref_in;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff  <= ref_ff * ctrl_ff[14:8];
               state_ff <= S_FMUL;
            end
            S_FMUL: begin
               fprod_ff <= prod_ff * frac_ff[15:0];
               state_ff <= S_SUM;
            end
            S_SUM: begin
               rpll_ff <= rpll_in;
               err_ff  <= err_in;
               quot_ff <= src_in;
               rem_ff  <= '0;
               div_ff  <= ls_ff[13:8];
               cnt_ff  <= CW'(DIV_STEPS);
               if (err_in || !ls_ff[24] || ls_ff[13:8] == '0) begin
                  quot_ff  <= '0;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff   <= fits ? 6'(shifted - {1'b0, div_ff}) : shifted[5:0];
               quot_ff  <= {quot_ff[RW-2:0], fits};
               cnt_ff   <= cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_read_data_ff <= read_data_ff;
                  rsp_rpll_ff      <= rpll_ff;
                  rsp_lsbus_ff     <= quot_ff;
                  rsp_rst_req_ff   <= rst_req_ff;
                  rsp_err_ff       <= err_ff;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.read_data     = rsp_read_data_ff;
   assign rsp_bus.rpll_rate     = rsp_rpll_ff;
   assign rsp_bus.lsbus_rate    = rsp_lsbus_ff;
   assign rsp_bus.reset_request = rsp_rst_req_ff;
   assign rsp_bus.source_error  = rsp_err_ff;

   `CRR_ASSERT(a_div_count_live, clock, reset, (state_ff == S_DIV) |-> (cnt_ff != '0))
   `CRR_ASSERT_NEXT(a_done_holds, clock, reset, (state_ff == S_DONE) && !rsp_free, (state_ff == S_DONE) && rsp_valid_ff)
   `CRR_ASSERT(a_err_zero_rate, clock, reset, rsp_valid_ff && rsp_err_ff |-> (rsp_lsbus_ff == '0))
   `CRR_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == S_IDX)
endmodule
`default_nettype wire
